>>> rtl/servo_feedback_fault_monitor_core_macros.svh
// Assertion helpers used by the monitor core.
`ifndef SERVO_FEEDBACK_FAULT_MONITOR_CORE_MACROS_SVH
`define SERVO_FEEDBACK_FAULT_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SFFM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sffm: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SFFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sffm: next-cycle check failed");

`endif

>>> rtl/sffm_pkg.sv
`timescale 1ns / 1ps
package sffm_pkg;

    localparam int COUNTER_BITS_DEF = 11;
    localparam int LIMIT_W          = 11;
    localparam int CFG_ADDR_W       = 5;

    // Serial multiplier geometry: signed multiplicand, unsigned multiplier.
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 32;
    localparam int MUL_HI_W  = MUL_A_W + 1;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam logic [MUL_CNT_W-1:0] MUL_STEPS_FULL = MUL_CNT_W'(MUL_B_W);
    localparam logic [MUL_CNT_W-1:0] MUL_STEPS_HALF = MUL_CNT_W'(MUL_B_W / 2);

    // Filter coefficients, Q0.16.
    localparam logic [MUL_B_W-1:0] ALPHA_POS = 32'd6554;
    localparam logic [MUL_B_W-1:0] ALPHA_VEL = 32'd1311;
    localparam logic [MUL_B_W-1:0] ALPHA_CUR = 32'd655;

    localparam logic signed [15:0] DRIVE_MAX = 16'sd16384;
    localparam logic signed [15:0] DRIVE_MIN = -16'sd16384;

    localparam logic signed [31:0] VEL_SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VEL_SAT_MIN = 32'sh8000_0000;

    // Register reset values.
    localparam logic [31:0] POS_SCALE_RST     = 32'd6588397;
    localparam logic [31:0] VEL_SCALE_RST     = 32'd10053;
    localparam logic [14:0] CURRENT_LIMIT_RST = 15'd5000;
    localparam logic [14:0] COMMAND_MIN_RST   = 15'd8192;
    localparam logic [30:0] VEL_ERR_LIMIT_RST = 31'd91750;
    localparam logic [LIMIT_W-1:0] NE_LIMIT_RST = LIMIT_W'(500);
    localparam logic [LIMIT_W-1:0] WD_LIMIT_RST = LIMIT_W'(1000);
    localparam logic [LIMIT_W-1:0] OC_LIMIT_RST = LIMIT_W'(200);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_ZERO  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_POS_SCALE     = 3'd0,
        REG_VEL_SCALE     = 3'd1,
        REG_CURRENT_LIMIT = 3'd2,
        REG_COMMAND_MIN   = 3'd3,
        REG_VEL_ERR_LIMIT = 3'd4,
        REG_NE_LIMIT      = 3'd5,
        REG_WD_LIMIT      = 3'd6,
        REG_OC_LIMIT      = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] steps;
    } t_mul_req;

    typedef struct packed {
        logic clear;
        logic step;
        logic rearm;
    } t_persist_ctl;

endpackage

>>> rtl/sffm_in_if.sv
`timescale 1ns / 1ps
interface sffm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] encoder_count;
    logic signed [15:0] current_sample;
    logic signed [15:0] drive_request;
    logic signed [31:0] target_velocity;
    logic               limit_pressed;

    modport source (
        output valid, cmd, encoder_count, current_sample, drive_request,
               target_velocity, limit_pressed,
        input  ready
    );

    modport sink (
        input  valid, cmd, encoder_count, current_sample, drive_request,
               target_velocity, limit_pressed,
        output ready
    );
endinterface

>>> rtl/sffm_out_if.sv
`timescale 1ns / 1ps
interface sffm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_out;
    logic [2:0]         fault_bits;
    logic signed [31:0] position_filtered;
    logic signed [31:0] velocity_filtered;
    logic signed [15:0] current_filtered;

    modport source (
        output valid, drive_out, fault_bits, position_filtered, velocity_filtered,
               current_filtered,
        input  ready
    );

    modport sink (
        input  valid, drive_out, fault_bits, position_filtered, velocity_filtered,
               current_filtered,
        output ready
    );
endinterface

>>> rtl/servo_feedback_fault_monitor_core.sv
`timescale 1ns / 1ps
// Servo feedback fault monitor. A control tick (cmd 0) runs on the single bit-serial
// multiplier, which retires one multiplier bit per cycle: a tick needs two 32-bit
// scale products and three 16-bit filter products, followed by a fault-check state
// and an output state. Clear, zero and unused commands go from idle straight to the
// output state. The core works on one beat at a time: the input is ready only while
// the sequencer is idle, and a finished result waits in the output register, so a
// new input beat is taken while the previous result is still unclaimed; a beat
// stalls in its output state only if that result is still not taken. The user must
// write configuration through the APB port only while no beat is in flight; the block
// itself does not enforce this. pready is always high.
`include "servo_feedback_fault_monitor_core_macros.svh"
module servo_feedback_fault_monitor_core import sffm_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sffm_in_if.sink               i_item,
    sffm_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS_MUL,
        S_POS_EMA,
        S_VEL_MUL,
        S_VEL_EMA,
        S_CUR_EMA,
        S_CHECK,
        S_DONE
    } t_state;

    // Configuration registers.
    logic [31:0]        r_pos_scale;
    logic [31:0]        r_vel_scale;
    logic [14:0]        r_current_limit;
    logic [14:0]        r_command_min;
    logic [30:0]        r_vel_err_limit;
    logic [LIMIT_W-1:0] r_ne_limit;
    logic [LIMIT_W-1:0] r_wd_limit;
    logic [LIMIT_W-1:0] r_oc_limit;

    // Sequencer and monitor state.
    t_state             r_state, n_state;
    logic [1:0]         r_cmd;
    logic signed [15:0] r_cur_sample;
    logic signed [15:0] r_drive_req;
    logic signed [31:0] r_target;
    logic               r_pressed;
    logic [15:0]        r_enc;
    logic signed [15:0] r_delta;
    logic [15:0]        r_prev_count;
    logic signed [31:0] r_pos_avg;
    logic signed [31:0] r_vel_avg;
    logic signed [31:0] r_cur_avg;
    logic [14:0]        r_last_drive;
    logic [2:0]         r_fault;

    // Output register.
    logic               r_out_valid;
    logic signed [15:0] r_out_drive;
    logic [2:0]         r_out_fault;
    logic signed [31:0] r_out_pos;
    logic signed [31:0] r_out_vel;
    logic signed [15:0] r_out_cur;

    logic accept;
    logic out_take;
    logic cfg_write;
    t_reg_idx cfg_idx;

    // Shared multiplier.
    t_mul_req                   mul_req;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic        [MUL_B_W-1:0]  mul_b;
    logic                       mul_busy;
    logic signed [MUL_HI_W-1:0] mul_hi;
    logic        [MUL_B_W-1:0]  mul_lo;

    logic signed [31:0]        pos_sample;
    logic signed [31:0]        vel_sample;
    logic                      vel_fits;
    logic signed [31:0]        cur_wide;
    logic signed [MUL_A_W-1:0] pos_diff;
    logic signed [MUL_A_W-1:0] vel_diff;
    logic signed [MUL_A_W-1:0] cur_diff;

    // Fault checks.
    logic               stall_cond;
    logic               sign_differs;
    logic signed [32:0] tgt_err;
    logic [32:0]        tgt_err_abs;
    logic               wrong_dir_cond;
    logic [31:0]        cur_abs;
    logic               oc_cond;
    t_persist_ctl       ne_ctl, wd_ctl, oc_ctl;
    logic               ne_over, wd_over, oc_over;
    logic               clear_cmd;

    // Drive gating.
    logic signed [15:0] drive_sat;
    logic signed [15:0] drive_gated;
    logic signed [15:0] drive_result;
    logic [15:0]        drive_mag;

    assign accept    = i_item.valid && i_item.ready;
    assign out_take  = !r_out_valid || o_result.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign pready    = 1'b1;

    assign i_item.ready = (r_state == S_IDLE);

    sffm_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_hi    (mul_hi),
        .o_lo    (mul_lo)
    );

    // Full 32-step product is {hi, lo}; floor by 2^16 keeps its middle 32 bits.
    assign pos_sample = {mul_hi[15:0], mul_lo[31:16]};
    assign vel_fits   = (mul_hi == {MUL_HI_W{mul_lo[31]}});
    assign vel_sample = vel_fits ? mul_lo :
                        (mul_hi[MUL_HI_W-1] ? VEL_SAT_MIN : VEL_SAT_MAX);
    assign cur_wide   = {r_cur_sample, 16'h0000};
    assign pos_diff   = MUL_A_W'(pos_sample) - MUL_A_W'(r_pos_avg);
    assign vel_diff   = MUL_A_W'(vel_sample) - MUL_A_W'(r_vel_avg);
    assign cur_diff   = MUL_A_W'(cur_wide) - MUL_A_W'(r_cur_avg);

    // Sequencer: launch the next product in the cycle the previous one lands.
    always_comb begin
        n_state       = r_state;
        mul_req.start = 1'b0;
        mul_req.steps = MUL_STEPS_FULL;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.cmd == CMD_TICK) begin
                        mul_req.start = 1'b1;
                        mul_a         = MUL_A_W'(i_item.encoder_count);
                        mul_b         = r_pos_scale;
                        n_state       = S_POS_MUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_POS_MUL: begin
                if (!mul_busy) begin
                    mul_req.start = 1'b1;
                    mul_req.steps = MUL_STEPS_HALF;
                    mul_a         = pos_diff;
                    mul_b         = ALPHA_POS;
                    n_state       = S_POS_EMA;
                end
            end
            S_POS_EMA: begin
                if (!mul_busy) begin
                    mul_req.start = 1'b1;
                    mul_a         = MUL_A_W'(r_delta);
                    mul_b         = r_vel_scale;
                    n_state       = S_VEL_MUL;
                end
            end
            S_VEL_MUL: begin
                if (!mul_busy) begin
                    mul_req.start = 1'b1;
                    mul_req.steps = MUL_STEPS_HALF;
                    mul_a         = vel_diff;
                    mul_b         = ALPHA_VEL;
                    n_state       = S_VEL_EMA;
                end
            end
            S_VEL_EMA: begin
                if (!mul_busy) begin
                    mul_req.start = 1'b1;
                    mul_req.steps = MUL_STEPS_HALF;
                    mul_a         = cur_diff;
                    mul_b         = ALPHA_CUR;
                    n_state       = S_CUR_EMA;
                end
            end
            S_CUR_EMA: begin
                if (!mul_busy) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_take) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Fault conditions, evaluated on the freshly updated averages.
    assign stall_cond   = (r_delta == 16'sd0) && (r_last_drive > r_command_min);
    assign sign_differs = ((r_vel_avg == 32'sd0) != (r_target == 32'sd0)) ||
                          ((r_vel_avg != 32'sd0) && (r_target != 32'sd0) &&
                           (r_vel_avg[31] != r_target[31]));
    assign tgt_err        = 33'(r_target) - 33'(r_vel_avg);
    assign tgt_err_abs    = tgt_err[32] ? -tgt_err : tgt_err;
    assign wrong_dir_cond = sign_differs && (tgt_err_abs > 33'(r_vel_err_limit));
    assign cur_abs        = r_cur_avg[31] ? -r_cur_avg : r_cur_avg;
    assign oc_cond        = cur_abs >= {1'b0, r_current_limit, 16'h0000};

    assign clear_cmd = accept && ((i_item.cmd == CMD_CLEAR) || (i_item.cmd == CMD_ZERO));

    always_comb begin
        ne_ctl.clear = clear_cmd;
        ne_ctl.step  = (r_state == S_CHECK);
        ne_ctl.rearm = 1'b0;
        wd_ctl       = ne_ctl;
        // Overcurrent counter starts over once its fault latches.
        oc_ctl       = ne_ctl;
        oc_ctl.rearm = 1'b1;
    end

    sffm_persist #(.COUNTER_BITS(COUNTER_BITS)) u_no_encoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ne_ctl),
        .i_cond  (stall_cond),
        .i_limit (r_ne_limit),
        .o_over  (ne_over)
    );

    sffm_persist #(.COUNTER_BITS(COUNTER_BITS)) u_wrong_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (wd_ctl),
        .i_cond  (wrong_dir_cond),
        .i_limit (r_wd_limit),
        .o_over  (wd_over)
    );

    sffm_persist #(.COUNTER_BITS(COUNTER_BITS)) u_overcurrent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (oc_ctl),
        .i_cond  (oc_cond),
        .i_limit (r_oc_limit),
        .o_over  (oc_over)
    );

    // Clamp the request, then drop it on any fault, when pushing into the limit, or for a non-tick command.
    always_comb begin
        if (r_drive_req > DRIVE_MAX) begin
            drive_sat = DRIVE_MAX;
        end else if (r_drive_req < DRIVE_MIN) begin
            drive_sat = DRIVE_MIN;
        end else begin
            drive_sat = r_drive_req;
        end
        if (r_fault != 3'b000) begin
            drive_gated = '0;
        end else if (r_pressed && drive_sat[15]) begin
            drive_gated = '0;
        end else begin
            drive_gated = drive_sat;
        end
        drive_result = (r_cmd == CMD_TICK) ? drive_gated : 16'sd0;
        drive_mag    = drive_gated[15] ? -drive_gated : drive_gated;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_scale     <= POS_SCALE_RST;
            r_vel_scale     <= VEL_SCALE_RST;
            r_current_limit <= CURRENT_LIMIT_RST;
            r_command_min   <= COMMAND_MIN_RST;
            r_vel_err_limit <= VEL_ERR_LIMIT_RST;
            r_ne_limit      <= NE_LIMIT_RST;
            r_wd_limit      <= WD_LIMIT_RST;
            r_oc_limit      <= OC_LIMIT_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_POS_SCALE:     r_pos_scale     <= pwdata;
                REG_VEL_SCALE:     r_vel_scale     <= pwdata;
                REG_CURRENT_LIMIT: r_current_limit <= pwdata[14:0];
                REG_COMMAND_MIN:   r_command_min   <= pwdata[14:0];
                REG_VEL_ERR_LIMIT: r_vel_err_limit <= pwdata[30:0];
                REG_NE_LIMIT:      r_ne_limit      <= pwdata[LIMIT_W-1:0];
                REG_WD_LIMIT:      r_wd_limit      <= pwdata[LIMIT_W-1:0];
                REG_OC_LIMIT:      r_oc_limit      <= pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_POS_SCALE:     prdata = r_pos_scale;
            REG_VEL_SCALE:     prdata = r_vel_scale;
            REG_CURRENT_LIMIT: prdata = 32'(r_current_limit);
            REG_COMMAND_MIN:   prdata = 32'(r_command_min);
            REG_VEL_ERR_LIMIT: prdata = 32'(r_vel_err_limit);
            REG_NE_LIMIT:      prdata = 32'(r_ne_limit);
            REG_WD_LIMIT:      prdata = 32'(r_wd_limit);
            REG_OC_LIMIT:      prdata = 32'(r_oc_limit);
        endcase
    end

    // Sequencer state, monitor state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_count <= '0;
            r_pos_avg    <= '0;
            r_vel_avg    <= '0;
            r_cur_avg    <= '0;
            r_last_drive <= '0;
            r_fault      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (accept) begin
                // Capture the beat; the delta uses the count of the previous tick.
                r_cmd        <= i_item.cmd;
                r_cur_sample <= i_item.current_sample;
                r_drive_req  <= i_item.drive_request;
                r_target     <= i_item.target_velocity;
                r_pressed    <= i_item.limit_pressed;
                r_enc        <= i_item.encoder_count;
                r_delta      <= i_item.encoder_count - r_prev_count;
                if (i_item.cmd == CMD_CLEAR) begin
                    r_fault <= '0;
                end
                if (i_item.cmd == CMD_ZERO) begin
                    r_fault      <= '0;
                    r_prev_count <= '0;
                    r_pos_avg    <= '0;
                end
            end

            // Filter updates: avg + floor(diff * alpha / 2^16), wrapped to 32 bits.
            if (!mul_busy) begin
                if (r_state == S_POS_EMA) begin
                    r_pos_avg <= r_pos_avg + mul_hi[31:0];
                end
                if (r_state == S_VEL_EMA) begin
                    r_vel_avg <= r_vel_avg + mul_hi[31:0];
                end
                if (r_state == S_CUR_EMA) begin
                    r_cur_avg <= r_cur_avg + mul_hi[31:0];
                end
            end

            // Latch any fault whose counter passed its limit this tick.
            if (r_state == S_CHECK) begin
                r_fault <= r_fault | {oc_over, wd_over, ne_over};
            end

            if (r_state == S_DONE && out_take) begin
                r_out_valid <= 1'b1;
                r_out_drive <= drive_result;
                r_out_fault <= r_fault;
                r_out_pos   <= r_pos_avg;
                r_out_vel   <= r_vel_avg;
                r_out_cur   <= r_cur_avg[31:16];
                if (r_cmd == CMD_TICK) begin
                    r_last_drive <= drive_mag[14:0];
                    r_prev_count <= r_enc;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.drive_out         = r_out_drive;
    assign o_result.fault_bits        = r_out_fault;
    assign o_result.position_filtered = r_out_pos;
    assign o_result.velocity_filtered = r_out_vel;
    assign o_result.current_filtered  = r_out_cur;

    `SFFM_ASSERT_IMPLY(a_idle_mul_quiet, i_clk, i_rst_n, r_state == S_IDLE, !mul_busy)
    `SFFM_ASSERT_IMPLY(a_mul_start_free, i_clk, i_rst_n, mul_req.start, !mul_busy)
    `SFFM_ASSERT_NEXT(a_fault_sticky, i_clk, i_rst_n, !clear_cmd, (r_fault & $past(r_fault)) == $past(r_fault))
    `SFFM_ASSERT_IMPLY(a_drive_needs_clean, i_clk, i_rst_n, o_result.valid && o_result.drive_out != 16'sd0, o_result.fault_bits == 3'b000)

endmodule

>>> rtl/sffm_serial_mul.sv
`timescale 1ns / 1ps
module sffm_serial_mul import sffm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mul_req                   i_req,
    input  logic signed [MUL_A_W-1:0]  i_a,
    input  logic        [MUL_B_W-1:0]  i_b,
    output logic                       o_busy,
    output logic signed [MUL_HI_W-1:0] o_hi,
    output logic        [MUL_B_W-1:0]  o_lo
);

    logic signed [MUL_A_W-1:0]  r_a;
    logic signed [MUL_HI_W-1:0] r_hi;
    logic        [MUL_B_W-1:0]  r_lo;
    logic        [MUL_CNT_W-1:0] r_cnt;

    logic signed [MUL_HI_W-1:0] addend;
    logic signed [MUL_HI_W-1:0] sum;

    // One multiplier bit per cycle, LSB first; the product shifts into r_lo.
    assign addend = r_lo[0] ? MUL_HI_W'(r_a) : '0;
    assign sum    = r_hi + addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= i_req.steps;
            r_a   <= i_a;
            r_hi  <= '0;
            r_lo  <= i_b;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_hi  <= {sum[MUL_HI_W-1], sum[MUL_HI_W-1:1]};
            r_lo  <= {sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;

endmodule

>>> rtl/sffm_persist.sv
`timescale 1ns / 1ps
module sffm_persist import sffm_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_persist_ctl       i_ctl,
    input  logic               i_cond,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_over
);

    localparam int CMP_W = (COUNTER_BITS > LIMIT_W) ? COUNTER_BITS : LIMIT_W;

    logic [COUNTER_BITS-1:0] r_ticks;
    logic [COUNTER_BITS-1:0] ticks_up;
    logic [COUNTER_BITS-1:0] n_ticks;

    // Saturate at all ones; drop to zero as soon as the condition goes away.
    assign ticks_up = (&r_ticks) ? r_ticks : r_ticks + 1'b1;
    assign n_ticks  = i_cond ? ticks_up : '0;
    assign o_over   = CMP_W'(n_ticks) > CMP_W'(i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
        end else if (i_ctl.clear) begin
            r_ticks <= '0;
        end else if (i_ctl.step) begin
            r_ticks <= (i_ctl.rearm && o_over) ? '0 : n_ticks;
        end
    end

endmodule

>>> test/sffm_status_checker.sv
`timescale 1ns / 1ps
module sffm_status_checker import sffm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sffm_in_if                    i_item,
    sffm_out_if                   i_status,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam longint POS_GAIN    = 6554;
    localparam longint VEL_GAIN    = 1311;
    localparam longint CUR_GAIN    = 655;
    localparam longint DRIVE_LIMIT = 16384;
    localparam longint VEL_TOP     = 64'sd2147483647;
    localparam longint VEL_BOTTOM  = -64'sd2147483648;
    localparam int     TICKS_TOP   = (1 << COUNTER_BITS_DEF) - 1;
    localparam int     REPORT_MAX  = 10;

    typedef struct packed {
        logic signed [15:0] drive;
        logic [2:0]         faults;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [15:0] current;
    } t_status_beat;

    // Register copies, kept at the block's widths.
    logic [31:0]        pos_scale_q;
    logic [31:0]        vel_scale_q;
    logic [14:0]        current_limit_q;
    logic [14:0]        command_min_q;
    logic [30:0]        vel_err_limit_q;
    logic [LIMIT_W-1:0] stall_limit_q;
    logic [LIMIT_W-1:0] reverse_limit_q;
    logic [LIMIT_W-1:0] overload_limit_q;

    logic [15:0]        prev_count;
    logic signed [31:0] pos_avg;
    logic signed [31:0] vel_avg;
    logic signed [31:0] cur_avg;
    longint             last_mag;
    int                 stall_ticks;
    int                 reverse_ticks;
    int                 overload_ticks;
    logic [2:0]         faults;

    t_status_beat status_due[$];
    int           mismatches = 0;

    function automatic void clear_faults();
        faults         = '0;
        stall_ticks    = 0;
        reverse_ticks  = 0;
        overload_ticks = 0;
    endfunction

    function automatic void reset_model();
        pos_scale_q      = 32'd6588397;
        vel_scale_q      = 32'd10053;
        current_limit_q  = 15'd5000;
        command_min_q    = 15'd8192;
        vel_err_limit_q  = 31'd91750;
        stall_limit_q    = LIMIT_W'(500);
        reverse_limit_q  = LIMIT_W'(1000);
        overload_limit_q = LIMIT_W'(200);
        prev_count       = '0;
        pos_avg          = '0;
        vel_avg          = '0;
        cur_avg          = '0;
        last_mag         = 0;
        clear_faults();
    endfunction

    function automatic void write_config(logic [2:0] idx, logic [31:0] value);
        case (t_reg_idx'(idx))
            REG_POS_SCALE:     pos_scale_q      = value;
            REG_VEL_SCALE:     vel_scale_q      = value;
            REG_CURRENT_LIMIT: current_limit_q  = value[14:0];
            REG_COMMAND_MIN:   command_min_q    = value[14:0];
            REG_VEL_ERR_LIMIT: vel_err_limit_q  = value[30:0];
            REG_NE_LIMIT:      stall_limit_q    = value[LIMIT_W-1:0];
            REG_WD_LIMIT:      reverse_limit_q  = value[LIMIT_W-1:0];
            default:           overload_limit_q = value[LIMIT_W-1:0];
        endcase
    endfunction

    // One averaging step: avg + floor((sample - avg) * gain / 2^16), wrapped to 32 bits.
    function automatic logic signed [31:0] smooth(logic signed [31:0] avg, longint target,
                                                  longint gain);
        longint d;
        d = target - longint'(avg);
        return longint'(avg) + ((d * gain) >>> 16);
    endfunction

    function automatic int sign3(longint v);
        if (v > 0) return 1;
        if (v < 0) return -1;
        return 0;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int count_on(bit hold, int ticks);
        if (!hold) return 0;
        return (ticks < TICKS_TOP) ? ticks + 1 : TICKS_TOP;
    endfunction

    function automatic t_status_beat predict_status(
        logic [1:0] cmd, logic signed [15:0] enc, logic signed [15:0] cur,
        logic signed [15:0] drv, logic signed [31:0] tgt, logic pressed
    );
        t_status_beat r;
        logic [15:0]  step16;
        longint       delta;
        longint       vel_in;
        longint       drive;
        longint       tgt_l;
        bit           cond;
        r.drive = '0;
        case (cmd)
            CMD_CLEAR: clear_faults();
            CMD_ZERO: begin
                prev_count = '0;
                pos_avg    = '0;
                clear_faults();
            end
            CMD_TICK: begin
                step16 = enc - prev_count;
                delta  = longint'($signed(step16));
                pos_avg = smooth(pos_avg,
                                 (longint'(enc) * longint'({32'd0, pos_scale_q})) >>> 16,
                                 POS_GAIN);
                vel_in = delta * longint'({32'd0, vel_scale_q});
                if (vel_in > VEL_TOP) vel_in = VEL_TOP;
                if (vel_in < VEL_BOTTOM) vel_in = VEL_BOTTOM;
                vel_avg = smooth(vel_avg, vel_in, VEL_GAIN);
                cur_avg = smooth(cur_avg, longint'(cur) * 65536, CUR_GAIN);

                cond = (delta == 0) && (last_mag > longint'({49'd0, command_min_q}));
                stall_ticks = count_on(cond, stall_ticks);
                if (stall_ticks > int'(stall_limit_q)) faults[0] = 1'b1;

                tgt_l = longint'(tgt);
                cond = (sign3(vel_avg) != sign3(tgt_l)) &&
                       (magnitude(tgt_l - longint'(vel_avg)) >
                        longint'({33'd0, vel_err_limit_q}));
                reverse_ticks = count_on(cond, reverse_ticks);
                if (reverse_ticks > int'(reverse_limit_q)) faults[1] = 1'b1;

                cond = magnitude(longint'(cur_avg)) >=
                       longint'({49'd0, current_limit_q}) * 65536;
                overload_ticks = count_on(cond, overload_ticks);
                if (overload_ticks > int'(overload_limit_q)) begin
                    faults[2]      = 1'b1;
                    overload_ticks = 0;
                end

                drive = longint'(drv);
                if (drive > DRIVE_LIMIT) drive = DRIVE_LIMIT;
                if (drive < -DRIVE_LIMIT) drive = -DRIVE_LIMIT;
                if (faults != '0) begin
                    drive = 0;
                end else if (pressed && drive < 0) begin
                    drive = 0;
                end
                r.drive    = 16'(drive);
                last_mag   = magnitude(drive);
                prev_count = enc;
            end
            default: ;
        endcase
        r.faults   = faults;
        r.position = pos_avg;
        r.velocity = vel_avg;
        r.current  = cur_avg[31:16];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_status_beat seen;
        t_status_beat want;
        if (!i_rst_n) begin
            reset_model();
            status_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                write_config(i_paddr[4:2], i_pwdata);
            end
            if (i_status.valid && i_status.ready) begin
                seen = '{i_status.drive_out, i_status.fault_bits, i_status.position_filtered,
                         i_status.velocity_filtered, i_status.current_filtered};
                if (status_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("status beat with nothing outstanding: drive %0d faults %0d",
                                 seen.drive, seen.faults);
                    end
                end else begin
                    want = status_due.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("status mismatch (expected/actual): drive %0d/%0d faults %0d/%0d pos %0d/%0d vel %0d/%0d cur %0d/%0d",
                                     want.drive, seen.drive, want.faults, seen.faults,
                                     want.position, seen.position, want.velocity,
                                     seen.velocity, want.current, seen.current);
                        end
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                status_due.push_back(predict_status(i_item.cmd, i_item.encoder_count,
                                                    i_item.current_sample, i_item.drive_request,
                                                    i_item.target_velocity,
                                                    i_item.limit_pressed));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= status_due.size();
    end

endmodule

>>> test/servo_feedback_fault_monitor_core_test.sv
`timescale 1ns / 1ps
module servo_feedback_fault_monitor_core_test;
    import sffm_pkg::*;

    // The block never defines cmd 3; it must report state and leave it alone.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RESET_CYCLES   = 4;
    // The longest honest silence is the receiver hold-off.
    localparam int QUIET_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 130;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_BEATS    = 154;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum int {
        CFG_TIGHT,
        CFG_ZERO,
        CFG_MAX,
        CFG_WIDE,
        CFG_DEFAULT
    } t_cfg_kind;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    sffm_in_if  item_bus ();
    sffm_out_if status_bus ();

    int fail_count;
    int pending;

    // Idling knobs: the sender percentage is used only by the stimulus process,
    // the receiver one crosses processes and so only changes by nonblocking writes.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Bump to ask the receiver for one long hold-off.
    int holdoff_seq    = 0;

    // Stimulus-side memory: last encoder count sent and this phase's current level.
    logic signed [15:0] last_enc = '0;
    int                 cur_bias = 0;

    servo_feedback_fault_monitor_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (status_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sffm_status_checker status_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_bus),
        .i_status     (status_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: take status beats at the current stall rate, or hold off entirely
    // for a long stretch when asked, so the core fills up and stops taking input.
    initial begin : result_sink
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        status_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_seq != seen_seq) begin
                seen_seq  = holdoff_seq;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                status_bus.ready <= 1'b0;
            end else begin
                status_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((item_bus.valid && item_bus.ready) || (status_bus.valid && status_bus.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 65;
                recv_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 65;
            end
            default: begin
                send_idle_pct  = 8;
                recv_stall_pct <= 8;
            end
        endcase
    endtask

    // Offer one input beat, idling first at the sender rate, and hold it until taken.
    // Valid stays high into the next call unless that call idles.
    task automatic send_beat(logic [1:0] cmd, logic signed [15:0] enc,
                             logic signed [15:0] cur, logic signed [15:0] drv,
                             logic signed [31:0] tgt, logic pressed);
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid           <= 1'b1;
        item_bus.cmd             <= cmd;
        item_bus.encoder_count   <= enc;
        item_bus.current_sample  <= cur;
        item_bus.drive_request   <= drv;
        item_bus.target_velocity <= tgt;
        item_bus.limit_pressed   <= pressed;
        do @(posedge i_clk); while (!item_bus.ready);
        // Track what the core now holds as its previous count.
        if (cmd == CMD_TICK) begin
            last_enc = enc;
        end else if (cmd == CMD_ZERO) begin
            last_enc = '0;
        end
    endtask

    // Mostly well-formed ticks: the encoder often holds still or creeps, the current
    // sits near a phase level so the average crosses limits, and commands are sparse.
    task automatic send_random_beat();
        int                 pick;
        int                 cur_i;
        logic [1:0]         cmd;
        logic signed [15:0] enc;
        logic signed [15:0] cur;
        logic signed [15:0] drv;
        logic signed [31:0] tgt;
        pick = $urandom_range(99);
        if (pick < 3) begin
            cmd = CMD_CLEAR;
        end else if (pick < 5) begin
            cmd = CMD_ZERO;
        end else if (pick < 6) begin
            cmd = CMD_UNUSED;
        end else begin
            cmd = CMD_TICK;
        end

        case ($urandom_range(9))
            0, 1, 2, 3: enc = last_enc;
            4, 5, 6, 7: enc = last_enc + 16'($urandom_range(16)) - 16'd8;
            default:    enc = $urandom;
        endcase

        if ($urandom_range(9) < 6) begin
            cur_i = cur_bias + int'($urandom_range(1000)) - 500;
            if (cur_i > 32767) cur_i = 32767;
            if (cur_i < -32768) cur_i = -32768;
            cur = 16'(cur_i);
        end else begin
            cur = $urandom;
        end

        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: drv = 16'(int'($urandom_range(32768)) - 16384);
            6:                drv = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            7, 8:             drv = $urandom;
            default:          drv = '0;
        endcase

        case ($urandom_range(4))
            0, 1:    tgt = $urandom;
            2, 3:    tgt = int'($urandom_range(400000)) - 200000;
            default: tgt = '0;
        endcase

        send_beat(cmd, enc, cur, drv, tgt, 1'($urandom_range(1)));
    endtask

    // Setup then access; the next write's setup follows straight on, so drop
    // psel only once the whole batch is done.
    task automatic write_register(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic configure(t_cfg_kind kind);
        logic [31:0] vals [8];
        case (kind)
            CFG_TIGHT: begin
                vals[REG_POS_SCALE]     = $urandom;
                vals[REG_VEL_SCALE]     = $urandom_range(1 << 20);
                vals[REG_CURRENT_LIMIT] = $urandom_range(3000, 20);
                vals[REG_COMMAND_MIN]   = $urandom_range(14000, 1000);
                vals[REG_VEL_ERR_LIMIT] = $urandom_range(1 << 22);
                vals[REG_NE_LIMIT]      = $urandom_range(12);
                vals[REG_WD_LIMIT]      = $urandom_range(12);
                vals[REG_OC_LIMIT]      = $urandom_range(12);
            end
            CFG_ZERO: begin
                foreach (vals[i]) vals[i] = '0;
            end
            CFG_MAX: begin
                vals[REG_POS_SCALE]     = 32'hFFFF_FFFF;
                vals[REG_VEL_SCALE]     = 32'hFFFF_FFFF;
                vals[REG_CURRENT_LIMIT] = 32'd32767;
                vals[REG_COMMAND_MIN]   = 32'd16384;
                vals[REG_VEL_ERR_LIMIT] = 32'h7FFF_FFFF;
                vals[REG_NE_LIMIT]      = 32'd2046;
                vals[REG_WD_LIMIT]      = 32'd2046;
                vals[REG_OC_LIMIT]      = 32'd2046;
            end
            CFG_WIDE: begin
                vals[REG_POS_SCALE]     = $urandom;
                vals[REG_VEL_SCALE]     = $urandom;
                vals[REG_CURRENT_LIMIT] = $urandom_range(32767);
                vals[REG_COMMAND_MIN]   = $urandom_range(16384);
                vals[REG_VEL_ERR_LIMIT] = $urandom & 32'h7FFF_FFFF;
                vals[REG_NE_LIMIT]      = $urandom_range(100);
                vals[REG_WD_LIMIT]      = $urandom_range(100);
                vals[REG_OC_LIMIT]      = $urandom_range(100);
            end
            default: begin
                vals[REG_POS_SCALE]     = 32'd6588397;
                vals[REG_VEL_SCALE]     = 32'd10053;
                vals[REG_CURRENT_LIMIT] = 32'd5000;
                vals[REG_COMMAND_MIN]   = 32'd8192;
                vals[REG_VEL_ERR_LIMIT] = 32'd91750;
                vals[REG_NE_LIMIT]      = 32'd500;
                vals[REG_WD_LIMIT]      = 32'd1000;
                vals[REG_OC_LIMIT]      = 32'd200;
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            write_register(t_reg_idx'(i), vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every status beat owed has been taken.
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_cfg_kind kind;
        i_rst_n                  <= 1'b0;
        item_bus.valid           <= 1'b0;
        item_bus.cmd             <= CMD_TICK;
        item_bus.encoder_count   <= '0;
        item_bus.current_sample  <= '0;
        item_bus.drive_request   <= '0;
        item_bus.target_velocity <= '0;
        item_bus.limit_pressed   <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset configuration, no idling.
        set_idling(IDLE_NONE);
        send_beat(CMD_TICK, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 1'b0);
        // Field maxima; the count jump is the largest forward delta.
        send_beat(CMD_TICK, 16'sh7FFF, 16'sh7FFF, 16'sd16384, 32'sh7FFF_FFFF, 1'b0);
        // Field minima with the limit pressed: negative drive gets zeroed.
        send_beat(CMD_TICK, 16'sh8000, 16'sh8000, -16'sd16384, 32'sh8000_0000, 1'b1);
        // Encoder still; drive above and below the legal range saturates.
        send_beat(CMD_TICK, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'sd0, 1'b0);
        send_beat(CMD_TICK, 16'sh8000, 16'sh8000, 16'sh8000, 32'sd0, 1'b0);
        // Positive drive passes a pressed limit, small negative one does not.
        send_beat(CMD_TICK, 16'sh8001, 16'sd100, 16'sd200, -32'sd5, 1'b1);
        send_beat(CMD_TICK, 16'sh8001, -16'sd100, -16'sd1, 32'sd5, 1'b1);
        send_beat(CMD_TICK, 16'sh7FFE, 16'sd0, 16'sd9000, -32'sd300000, 1'b0);
        send_beat(CMD_CLEAR, 16'sh1111, 16'sh2222, 16'sh3333, 32'sh4444_4444, 1'b1);
        send_beat(CMD_TICK, 16'sh0010, 16'sd5000, 16'sd12000, 32'sd200000, 1'b0);
        send_beat(CMD_ZERO, 16'sh5555, 16'shAAAA, 16'sh5555, 32'shAAAA_AAAA, 1'b0);
        send_beat(CMD_TICK, 16'sd0, -16'sd5000, -16'sd12000, -32'sd200000, 1'b0);
        send_beat(CMD_UNUSED, 16'sh1234, 16'sh7FFF, 16'sd16384, 32'sh7FFF_FFFF, 1'b1);
        send_beat(CMD_TICK, 16'sd1, 16'sd0, 16'sd16384, 32'sd0, 1'b0);
        send_beat(CMD_TICK, 16'sd1, 16'sd0, 16'sd16384, 32'sd0, 1'b0);

        // Random phases: each rewrites every register, picks an idling pattern and
        // a current level, then runs mostly well-formed control ticks.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                1:       kind = CFG_ZERO;
                3:       kind = CFG_MAX;
                5:       kind = CFG_WIDE;
                7:       kind = CFG_DEFAULT;
                default: kind = CFG_TIGHT;
            endcase
            drain_results();
            configure(kind);
            set_idling(t_idle_mode'(p % 4));
            cur_bias = int'($urandom_range(32767));
            if ($urandom_range(1)) cur_bias = -cur_bias;
            // Hold off the receiver while the sender keeps offering beats.
            if (p == 4) holdoff_seq <= holdoff_seq + 1;
            repeat (PHASE_BEATS) send_random_beat();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sffm_pkg.sv
rtl/sffm_in_if.sv
rtl/sffm_out_if.sv
rtl/sffm_serial_mul.sv
rtl/sffm_persist.sv
rtl/servo_feedback_fault_monitor_core.sv
test/sffm_status_checker.sv
test/servo_feedback_fault_monitor_core_test.sv
